[rtl/nfsa_pkg.sv]
// ----------------------------------------------------------------------------
// nfsa_pkg
// Types and constants shared by the next-fit sector allocator modules.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    // Request codes
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_MARK    = 2'd2;

    // Map marks
    localparam logic [1:0] MK_FREE    = 2'd0;
    localparam logic [1:0] MK_USED    = 2'd1;
    localparam logic [1:0] MK_BARRIER = 2'd2;
    localparam logic [1:0] MK_OTHER   = 2'd3;

    // Field widths and register defaults
    localparam int          SECTOR_W  = 12;
    localparam int          COUNT_W   = 13;
    localparam logic [12:0] COUNT_MAX = 13'h1FFF;
    localparam logic [11:0] CAP_RESET = 12'hFFF;

    // Request beat
    typedef struct packed {
        logic [1:0]          req_type;
        logic [SECTOR_W-1:0] sector;
        logic [1:0]          mark;
    } req_item_t;

    // Response beat
    typedef struct packed {
        logic                ok;
        logic [SECTOR_W-1:0] granted_sector;
        logic [COUNT_W-1:0]  used_count;
    } rsp_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REL,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic scan_step;
        logic rel_eval;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic rsp_free;
    } sts_t;

endpackage

[rtl/next_fit_sector_allocator_core.sv]
// Throughput: one request at a time; the scan walker checks one map entry per cycle
//   through the map's single read port.
// Reset: the map is swept to 'other' one entry per cycle, with req_ready low;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// next_fit_sector_allocator_core
// Next-fit sector allocator: allocate, release and mark requests on a 2-bit
// per-sector map, one response beat per request.
// ----------------------------------------------------------------------------
module next_fit_sector_allocator_core #(
    parameter int MAP_SECTORS  = 4096,
    parameter int RESERVED_LOW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  nfsa_pkg::req_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output nfsa_pkg::rsp_item_t  rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [11:0]          cfg_data
);

    nfsa_pkg::cmd_t cmd;
    nfsa_pkg::sts_t sts;

    // Capacity register always takes a write
    assign cfg_ready = 1'b1;

    // Controller
    nfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath
    nfsa_dp #(
        .MAP_SECTORS  (MAP_SECTORS),
        .RESERVED_LOW (RESERVED_LOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[rtl/nfsa_ram.sv]
// ----------------------------------------------------------------------------
// nfsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfsa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/nfsa_ctrl.sv]
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Request sequencer: clearing pass, request capture, scan, release check and
// commit of the result into the response register.
// ----------------------------------------------------------------------------
module nfsa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_type,
    output logic             req_ready,
    input  nfsa_pkg::sts_t   sts,
    output nfsa_pkg::cmd_t   cmd
);

    nfsa_pkg::state_t state_reg;
    nfsa_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfsa_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfsa_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = nfsa_pkg::ST_IDLE;
                end
            end
            nfsa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_type)
                        nfsa_pkg::REQ_ALLOC:   state_next = nfsa_pkg::ST_SCAN;
                        nfsa_pkg::REQ_RELEASE: state_next = nfsa_pkg::ST_REL;
                        default:               state_next = nfsa_pkg::ST_FINISH;
                    endcase
                end
            end
            nfsa_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = nfsa_pkg::ST_FINISH;
                end
            end
            nfsa_pkg::ST_REL:
            begin
                state_next = nfsa_pkg::ST_FINISH;
            end
            nfsa_pkg::ST_FINISH:
            begin
                if (sts.rsp_free)
                begin
                    state_next = nfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfsa_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            nfsa_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            nfsa_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            nfsa_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            nfsa_pkg::ST_REL:
            begin
                cmd.rel_eval = 1'b1;
            end
            nfsa_pkg::ST_FINISH:
            begin
                cmd.commit = sts.rsp_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/nfsa_dp.sv]
// ----------------------------------------------------------------------------
// nfsa_dp
// Datapath: sector map, next pointer, use count, capacity register, the
// two-stage scan walker (address issue, mark check) and the response register.
// ----------------------------------------------------------------------------
module nfsa_dp #(
    parameter int MAP_SECTORS  = 4096,
    parameter int RESERVED_LOW = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nfsa_pkg::cmd_t        cmd,
    output nfsa_pkg::sts_t        sts,
    input  nfsa_pkg::req_item_t   req,
    input  logic                  cfg_valid,
    input  logic [11:0]           cfg_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output nfsa_pkg::rsp_item_t   rsp
);

    localparam int AW       = $clog2(MAP_SECTORS);
    localparam int PTR_SPAN = (MAP_SECTORS > RESERVED_LOW) ? MAP_SECTORS : RESERVED_LOW + 1;
    localparam int PTR_W    = $clog2(PTR_SPAN);

    // Architectural state
    logic [11:0]                    cap_reg;
    logic [PTR_W-1:0]               np_reg;
    logic [nfsa_pkg::COUNT_W-1:0]   count_reg;
    logic [nfsa_pkg::COUNT_W-1:0]   count_next;
    logic [AW-1:0]                  clr_cnt_reg;

    // Captured request
    logic [1:0]                     rtype_reg;
    logic [nfsa_pkg::SECTOR_W-1:0]  sector_reg;
    logic [1:0]                     mark_reg;

    // Scan walker
    logic [PTR_W-1:0]               a_cur_reg;
    logic [PTR_W-1:0]               a_cur_next;
    logic [AW-1:0]                  b_cur_reg;
    logic [AW-1:0]                  b_cur_next;
    logic                           b_vld_reg;
    logic                           b_vld_next;
    logic                           wrap_reg;
    logic                           wrap_next;
    logic                           scan_hit;
    logic                           scan_fail;

    // Result
    logic                           res_ok_reg;
    logic [AW-1:0]                  res_sector_reg;
    logic                           rsp_valid_reg;
    nfsa_pkg::rsp_item_t            rsp_reg;

    // Map port signals
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [1:0]                     wr_data;
    logic [AW-1:0]                  rd_addr;
    logic [1:0]                     rd_data;

    // Misc
    logic [PTR_W-1:0]               top;
    logic                           a_out;
    logic                           a_start;
    logic                           b_free;
    logic                           b_bar;
    logic                           rel_ok;
    logic                           mark_ok;

    // Sector map
    nfsa_ram #(
        .WIDTH (2),
        .DEPTH (MAP_SECTORS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Top sector: capacity clamped to the map
    assign top = (32'(cap_reg) > 32'(MAP_SECTORS - 1)) ? PTR_W'(MAP_SECTORS - 1)
                                                       : PTR_W'(cap_reg);

    // Range checks
    assign a_out   = (32'(a_cur_reg) < 32'(RESERVED_LOW)) ||
                     (32'(a_cur_reg) >= 32'(MAP_SECTORS));
    assign a_start = (a_cur_reg == np_reg);
    assign b_free  = b_vld_reg && (rd_data == nfsa_pkg::MK_FREE);
    assign b_bar   = b_vld_reg && (rd_data == nfsa_pkg::MK_BARRIER);
    assign rel_ok  = (32'(sector_reg) >= 32'(RESERVED_LOW)) &&
                     (32'(sector_reg) <= 32'(top)) &&
                     (rd_data == nfsa_pkg::MK_USED);
    assign mark_ok = (req.req_type == nfsa_pkg::REQ_MARK) &&
                     (32'(req.sector) < 32'(MAP_SECTORS));

    // Read address: walker during a scan, request sector otherwise
    assign rd_addr = cmd.scan_step ? a_cur_reg[AW-1:0] : AW'(req.sector);

    // Scan step: stage B checks the mark read last cycle, stage A walks down
    always_comb
    begin
        a_cur_next = a_cur_reg;
        b_cur_next = b_cur_reg;
        b_vld_next = 1'b0;
        wrap_next  = wrap_reg;
        scan_hit   = 1'b0;
        scan_fail  = 1'b0;
        if (cmd.capture)
        begin
            a_cur_next = np_reg - PTR_W'(1);
            wrap_next  = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (b_free)
            begin
                scan_hit = 1'b1;
            end
            else if (b_bar || a_start == 1'b0 && a_out)
            begin
                // second wrap only repeats entries already seen
                if (wrap_reg)
                begin
                    scan_fail = 1'b1;
                end
                else
                begin
                    a_cur_next = top;
                    wrap_next  = 1'b1;
                end
            end
            else if (a_start)
            begin
                scan_fail = 1'b1;
            end
            else
            begin
                b_cur_next = a_cur_reg[AW-1:0];
                b_vld_next = 1'b1;
                a_cur_next = a_cur_reg - PTR_W'(1);
            end
        end
    end

    // Walker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cur_reg <= '0;
            b_cur_reg <= '0;
            b_vld_reg <= 1'b0;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            a_cur_reg <= a_cur_next;
            b_cur_reg <= b_cur_next;
            b_vld_reg <= b_vld_next;
            wrap_reg  <= wrap_next;
        end
    end

    // Captured request and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rtype_reg      <= req.req_type;
            sector_reg     <= req.sector;
            mark_reg       <= req.mark;
            res_ok_reg     <= mark_ok;
            res_sector_reg <= '0;
        end
        else if (scan_hit)
        begin
            res_ok_reg     <= 1'b1;
            res_sector_reg <= b_cur_reg;
        end
        else if (cmd.rel_eval)
        begin
            res_ok_reg <= rel_ok;
        end
    end

    // Map writes: clearing pass, then commit of a successful request
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(sector_reg);
        wr_data = mark_reg;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = nfsa_pkg::MK_OTHER;
        end
        else if (cmd.commit && res_ok_reg)
        begin
            unique case (rtype_reg)
                nfsa_pkg::REQ_ALLOC:
                begin
                    wr_en   = 1'b1;
                    wr_addr = res_sector_reg;
                    wr_data = nfsa_pkg::MK_USED;
                end
                nfsa_pkg::REQ_RELEASE:
                begin
                    wr_en   = 1'b1;
                    wr_data = nfsa_pkg::MK_FREE;
                end
                nfsa_pkg::REQ_MARK:
                begin
                    wr_en = 1'b1;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Use count after the request, saturating both ways
    always_comb
    begin
        count_next = count_reg;
        if (res_ok_reg)
        begin
            unique case (rtype_reg)
                nfsa_pkg::REQ_ALLOC:
                begin
                    if (count_reg != nfsa_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + nfsa_pkg::COUNT_W'(1);
                    end
                end
                nfsa_pkg::REQ_RELEASE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - nfsa_pkg::COUNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // State registers, clear counter, capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= nfsa_pkg::CAP_RESET;
            np_reg      <= PTR_W'(RESERVED_LOW);
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                if (res_ok_reg && (rtype_reg == nfsa_pkg::REQ_ALLOC))
                begin
                    np_reg <= PTR_W'(res_sector_reg);
                end
            end
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.ok             <= res_ok_reg;
            rsp_reg.granted_sector <= nfsa_pkg::SECTOR_W'(res_sector_reg);
            rsp_reg.used_count     <= count_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Status
    assign sts.clr_last  = (clr_cnt_reg == AW'(MAP_SECTORS - 1));
    assign sts.scan_done = scan_hit || scan_fail;
    assign sts.rsp_free  = !rsp_valid_reg || rsp_ready;

endmodule

[sim/next_fit_sector_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_sector_allocator_core_tb
// Self-checking bench for the next-fit sector allocator. A directed pass walks
// the wrap, barrier, release and capacity corner cases, then random traffic
// runs under three idling regimes, with one long response stall and one drain
// pause. Every response beat is checked against an in-bench allocation map.
// ----------------------------------------------------------------------------
module next_fit_sector_allocator_core_tb;

    localparam int         MAP_SECTORS  = 4096;
    localparam int         RESERVED_LOW = 64;
    localparam int         SCAN_LIMIT   = 2 * MAP_SECTORS + 4;
    localparam int         DRAIN_CYCLES = 50;
    localparam int         STALL_CYCLES = 300;
    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    nfsa_pkg::req_item_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    nfsa_pkg::rsp_item_t rsp;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [11:0]         cfg_data  = '0;

    // Shadow allocation state
    logic [1:0]          map_shadow [MAP_SECTORS];
    logic [11:0]         next_shadow;
    logic [12:0]         used_shadow;
    logic [11:0]         cap_shadow;
    nfsa_pkg::rsp_item_t pending_rsp [$];

    int   err_count     = 0;
    int   send_idle_pct = 22;
    int   recv_idle_pct = 45;
    int   stall_len     = 0;
    int   stall_left    = 0;
    logic stall_go      = 1'b0;
    logic stall_seen    = 1'b0;

    // Clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    next_fit_sector_allocator_core #(
        .MAP_SECTORS  (MAP_SECTORS),
        .RESERVED_LOW (RESERVED_LOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Works out the response to one request and advances the shadow map
    function automatic nfsa_pkg::rsp_item_t predict_rsp(nfsa_pkg::req_item_t r);
        nfsa_pkg::rsp_item_t o;
        int                  start;
        int                  cur;
        int                  n;
        bit                  done;
        o = '0;
        case (r.req_type)
            nfsa_pkg::REQ_ALLOC:
            begin
                // capacity is 12 bits, so it never exceeds the top map entry
                start = int'(next_shadow);
                cur   = start - 1;
                done  = 1'b0;
                for (n = 0; n < SCAN_LIMIT && !done; n++)
                begin
                    if (cur == start)
                        done = 1'b1;
                    else if (cur < RESERVED_LOW || cur >= MAP_SECTORS ||
                             map_shadow[cur] == nfsa_pkg::MK_BARRIER)
                        cur = int'(cap_shadow);
                    else if (map_shadow[cur] == nfsa_pkg::MK_FREE)
                    begin
                        map_shadow[cur] = nfsa_pkg::MK_USED;
                        next_shadow     = 12'(cur);
                        if (used_shadow != nfsa_pkg::COUNT_MAX)
                            used_shadow++;
                        o.ok             = 1'b1;
                        o.granted_sector = 12'(cur);
                        done             = 1'b1;
                    end
                    else
                        cur--;
                end
            end
            nfsa_pkg::REQ_RELEASE:
            begin
                if (r.sector >= RESERVED_LOW && r.sector <= cap_shadow &&
                    map_shadow[r.sector] == nfsa_pkg::MK_USED)
                begin
                    map_shadow[r.sector] = nfsa_pkg::MK_FREE;
                    if (used_shadow != 0)
                        used_shadow--;
                    o.ok = 1'b1;
                end
            end
            nfsa_pkg::REQ_MARK:
            begin
                // 12-bit sector always lands inside the map
                map_shadow[r.sector] = r.mark;
                o.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        o.used_count = used_shadow;
        return o;
    endfunction

    // One request beat; valid stays up after acceptance for the next caller
    task automatic send_req(input logic [1:0] kind, input logic [11:0] sec,
                            input logic [1:0] mk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= {kind, sec, mk};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp.push_back(predict_rsp(req));
    endtask

    // Drop valid and wait for every outstanding response
    task automatic wait_idle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    task automatic write_capacity(input logic [11:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cap_shadow  = value;
    endtask

    // Mostly well-formed traffic inside [RESERVED_LOW, capacity], some noise
    task automatic send_random_req();
        int          pick;
        int          span;
        int          tries;
        logic [1:0]  kind;
        logic [11:0] sec;
        logic [1:0]  mk;
        pick = $urandom_range(99);
        span = int'(cap_shadow) - RESERVED_LOW;
        kind = nfsa_pkg::REQ_ALLOC;
        sec  = 12'($urandom_range(MAP_SECTORS - 1));
        mk   = 2'($urandom_range(3));
        if (pick >= 40 && pick < 60)
        begin
            // aim releases at sectors currently in use
            kind = nfsa_pkg::REQ_RELEASE;
            sec  = next_shadow;
            for (tries = 0; tries < 8; tries++)
            begin
                sec = 12'(RESERVED_LOW + $urandom_range(span));
                if (map_shadow[sec] == nfsa_pkg::MK_USED)
                    break;
            end
            if (map_shadow[sec] != nfsa_pkg::MK_USED)
                sec = next_shadow;
        end
        else if (pick >= 60 && pick < 85)
        begin
            kind = nfsa_pkg::REQ_MARK;
            sec  = 12'(RESERVED_LOW + $urandom_range(span));
            pick = $urandom_range(99);
            if (pick < 70)
                mk = nfsa_pkg::MK_FREE;
            else if (pick < 80)
                mk = nfsa_pkg::MK_USED;
            else if (pick < 85)
                mk = nfsa_pkg::MK_BARRIER;
            else
                mk = nfsa_pkg::MK_OTHER;
        end
        else if (pick >= 85)
            kind = 2'($urandom_range(3));
        send_req(kind, sec, mk);
    endtask

    // Receiver: random idling, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (stall_go != stall_seen)
        begin
            stall_seen <= stall_go;
            stall_left <= stall_len;
            rsp_ready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin : rsp_check
        nfsa_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual ok=%0d sector=%0d count=%0d",
                         $time, rsp.ok, rsp.granted_sector, rsp.used_count);
                err_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("ok", want.ok, rsp.ok);
                check_field("granted_sector", want.granted_sector, rsp.granted_sector);
                check_field("used_count", want.used_count, rsp.used_count);
            end
        end
    end

    // Freshly cleared map: nothing to grant, refused release, count floor
    task automatic test_reset_state();
        write_capacity(nfsa_pkg::CAP_RESET);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd100, nfsa_pkg::MK_FREE);
        send_req(REQ_UNKNOWN, 12'd4095, nfsa_pkg::MK_BARRIER);
        send_req(nfsa_pkg::REQ_MARK, 12'd200, nfsa_pkg::MK_USED);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd200, nfsa_pkg::MK_OTHER);
    endtask

    // Wrap to the top sector, scan down to the low limit, then run dry
    task automatic test_alloc_wrap();
        send_req(nfsa_pkg::REQ_MARK, 12'd4095, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_MARK, 12'd64, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_MARK, 12'd63, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_MARK, 12'd0, nfsa_pkg::MK_USED);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
    endtask

    // Release of a used sector, of a free one, and below the reserved limit
    task automatic test_release_rules();
        send_req(nfsa_pkg::REQ_RELEASE, 12'd4095, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd4095, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd0, nfsa_pkg::MK_FREE);
    endtask

    // Barrier forces a wrap; a second barrier makes the scan loop until cut off
    task automatic test_barrier_wrap();
        write_capacity(12'd127);
        send_req(nfsa_pkg::REQ_MARK, 12'd80, nfsa_pkg::MK_BARRIER);
        send_req(nfsa_pkg::REQ_MARK, 12'd90, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_MARK, 12'd120, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_MARK, 12'd100, nfsa_pkg::MK_BARRIER);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
    endtask

    // Capacity at the reserved limit, then below it (the scan wraps and fails)
    task automatic test_capacity_extremes();
        write_capacity(12'd64);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd90, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd64, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        write_capacity(12'd0);
        send_req(nfsa_pkg::REQ_ALLOC, 12'd0, nfsa_pkg::MK_FREE);
        send_req(nfsa_pkg::REQ_RELEASE, 12'd64, nfsa_pkg::MK_FREE);
    endtask

    task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
        write_capacity(12'(RESERVED_LOW + $urandom_range(160)));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n)
            send_random_req();
    endtask

    // Long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        stall_len <= STALL_CYCLES;
        stall_go  <= ~stall_go;
        repeat (10)
            send_random_req();
    endtask

    // Sender stops until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        repeat (5)
            send_random_req();
        wait_idle();
        repeat (5)
            send_random_req();
    endtask

    // Main sequence
    initial
    begin
        for (int i = 0; i < MAP_SECTORS; i++)
            map_shadow[i] = nfsa_pkg::MK_OTHER;
        next_shadow = 12'(RESERVED_LOW);
        used_shadow = '0;
        cap_shadow  = nfsa_pkg::CAP_RESET;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_alloc_wrap();
        test_release_rules();
        test_barrier_wrap();
        test_capacity_extremes();
        test_random_traffic(30, 22, 45);
        test_backpressure();
        test_random_traffic(30, 45, 22);
        test_drain_pause();
        test_random_traffic(30, 0, 0);

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(50_000_000);
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
